[hw/rtl/pett_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic event timer table package
// Shared request codes, count modes, reset threshold, and slot, cell control,
// firing record and result types for the timer table and its cells.
// ----------------------------------------------------------------------------
package pett_pkg;

    localparam int            NUM_SLOTS     = 16;
    localparam int            SLOT_W        = 4;
    localparam logic [15:0]   THRESH_RESET  = 16'd900;

    localparam logic [2:0] REQ_TICK   = 3'd0;
    localparam logic [2:0] REQ_ADD    = 3'd1;
    localparam logic [2:0] REQ_REMOVE = 3'd2;
    localparam logic [2:0] REQ_QUERY  = 3'd3;
    localparam logic [2:0] REQ_CLEAR  = 3'd4;

    localparam logic [1:0] MODE_UP    = 2'd1;
    localparam logic [1:0] MODE_DOWN  = 2'd2;

    typedef struct packed {
        logic [15:0] remaining;
        logic        fire_each;
        logic [15:0] event_handle;
        logic [15:0] arg_handle;
        logic [1:0]  mode;
    } slot_data_t;

    typedef struct packed {
        logic add;
        logic drop;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic              fire;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       event_handle;
        logic [15:0]       arg_handle;
        logic [15:0]       count;
    } fire_rec_t;

    typedef struct packed {
        logic              fired;
        logic [SLOT_W-1:0] fired_slot;
        logic [15:0]       fired_event;
        logic [15:0]       fired_arg;
        logic [15:0]       fire_count;
        logic              found;
        logic [15:0]       remaining;
        logic              last;
    } result_t;

    function automatic result_t fire_result(fire_rec_t rec, logic last);
        result_t r;
        r             = '0;
        r.fired       = rec.fire;
        r.fired_slot  = rec.slot;
        r.fired_event = rec.event_handle;
        r.fired_arg   = rec.arg_handle;
        r.fire_count  = rec.count;
        r.last        = last;
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/pett_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Timer slot cell
// Holds one timer slot, loads or drops it on request, and updates it when the
// tick token passes through, handing the token to the next cell.
// ----------------------------------------------------------------------------
module pett_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pett_pkg::cell_ctrl_t   ctrl,
    input  pett_pkg::slot_data_t   add_data,
    input  logic [15:0]            tick_ms,
    input  logic [15:0]            threshold,
    input  logic                   tok_in,
    output logic                   tok_out,
    output logic                   valid,
    output logic [15:0]            remaining,
    output pett_pkg::fire_rec_t    rec
);
    import pett_pkg::*;

    logic        valid_reg, valid_next;
    logic        tok_reg, tok_next;
    logic [16:0] time_reg, time_next;
    logic [15:0] elapsed_reg, elapsed_next;
    slot_data_t  data_reg, data_next;

    logic [16:0] time_sum;
    logic        hit;
    logic        step;
    logic [15:0] count;

    assign step     = tok_reg && ctrl.shift && valid_reg;
    assign time_sum = time_reg + {1'b0, tick_ms};
    assign hit      = time_sum >= {1'b0, threshold};

    always_comb
    begin
        unique case (data_reg.mode)
            MODE_UP:   count = elapsed_reg;
            MODE_DOWN: count = data_reg.remaining;
            default:   count = '0;
        endcase
    end

    always_comb
    begin
        rec = '0;
        if (tok_reg && valid_reg && hit)
        begin
            rec.fire         = (data_reg.remaining == 16'd0) || data_reg.fire_each;
            rec.slot         = SLOT_W'(CELL_IDX);
            rec.event_handle = data_reg.event_handle;
            rec.arg_handle   = data_reg.arg_handle;
            rec.count        = count;
        end
    end

    always_comb
    begin
        valid_next   = valid_reg;
        time_next    = time_reg;
        elapsed_next = elapsed_reg;
        data_next    = data_reg;
        tok_next     = ctrl.shift ? tok_in : tok_reg;
        if (ctrl.add)
        begin
            valid_next   = 1'b1;
            time_next    = '0;
            elapsed_next = '0;
            data_next    = add_data;
        end
        else if (ctrl.drop)
        begin
            valid_next = 1'b0;
        end
        else if (step)
        begin
            if (hit)
            begin
                time_next = '0;
                if (data_reg.remaining == 16'd0)
                begin
                    valid_next = 1'b0;
                end
                else
                begin
                    elapsed_next       = elapsed_reg + 16'd1;
                    data_next.remaining = data_reg.remaining - 16'd1;
                end
            end
            else
            begin
                time_next = time_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg    <= time_next;
        elapsed_reg <= elapsed_next;
        data_reg    <= data_next;
    end

    assign tok_out   = tok_reg;
    assign valid     = valid_reg;
    assign remaining = data_reg.remaining;

endmodule
`default_nettype wire

[hw/rtl/periodic_event_timer_table_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic event timer table
// A row of timer slot cells with request decoding, tick walk control and a
// registered result stage.
// ----------------------------------------------------------------------------
// Add, remove, query, clear and unknown requests give their single result in
// the cycle after they are taken. A tick request passes a token along the row
// of SLOTS cells, one cell per cycle unless a held result waits on res_stall;
// no new request is taken until its last result has been registered.
module periodic_event_timer_table_top #(
    parameter int SLOTS = pett_pkg::NUM_SLOTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  req_type,
    input  logic [3:0]  slot,
    input  logic [15:0] tick_ms,
    input  logic [15:0] repeat_count,
    input  logic        fire_each_time,
    input  logic [15:0] event_handle,
    input  logic [15:0] arg_handle,
    input  logic [1:0]  count_mode,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        fired,
    output logic [3:0]  fired_slot,
    output logic [15:0] fired_event,
    output logic [15:0] fired_arg,
    output logic [15:0] fire_count,
    output logic        found,
    output logic [15:0] remaining,
    output logic        last
);
    import pett_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_WALK   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] thresh_reg;
    logic [15:0] tick_reg;
    result_t     res_reg, res_next;
    logic        res_valid_reg, res_valid_next;
    fire_rec_t   pend_reg, pend_next;
    logic        pend_valid_reg, pend_valid_next;

    cell_ctrl_t  ctrl [SLOTS];
    fire_rec_t   cell_rec [SLOTS];
    logic [15:0] cell_rem [SLOTS];
    logic [SLOTS-1:0] cell_valid;
    logic [SLOTS-1:0] tok_vec;
    logic [SLOTS-1:0] tok_in;

    slot_data_t  add_data;
    fire_rec_t   rec_sel;
    logic        out_free;
    logic        req_acc;
    logic        start;
    logic        adv;
    logic        in_range;
    logic        sel_valid;
    logic [15:0] sel_rem;

    assign out_free  = !res_valid_reg || !res_stall;
    assign req_stall = !((state_reg == ST_IDLE) && out_free);
    assign req_acc   = req_valid && !req_stall;
    assign start     = req_acc && (req_type == REQ_TICK);
    assign in_range  = 32'(slot) < SLOTS;
    assign adv       = (state_reg == ST_WALK) && (!(rec_sel.fire && pend_valid_reg) || out_free);

    assign add_data.remaining    = repeat_count;
    assign add_data.fire_each    = fire_each_time;
    assign add_data.event_handle = event_handle;
    assign add_data.arg_handle   = arg_handle;
    assign add_data.mode         = count_mode;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            ctrl[i].add   = req_acc && (req_type == REQ_ADD) && (32'(slot) == i);
            ctrl[i].drop  = req_acc && ((req_type == REQ_CLEAR)
                            || ((req_type == REQ_REMOVE) && (32'(slot) == i)));
            ctrl[i].shift = start || adv;
            tok_in[i]     = (i == 0) ? start : tok_vec[(i == 0) ? 0 : i - 1];
        end
    end

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        pett_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl[g]),
            .add_data  (add_data),
            .tick_ms   (tick_reg),
            .threshold (thresh_reg),
            .tok_in    (tok_in[g]),
            .tok_out   (tok_vec[g]),
            .valid     (cell_valid[g]),
            .remaining (cell_rem[g]),
            .rec       (cell_rec[g])
        );
    end

    always_comb
    begin
        rec_sel   = '0;
        sel_valid = 1'b0;
        sel_rem   = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            rec_sel = fire_rec_t'(rec_sel | cell_rec[i]);
            if (32'(slot) == i)
            begin
                sel_valid = cell_valid[i];
                sel_rem   = cell_rem[i];
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg && res_stall;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    if (req_type == REQ_TICK)
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        res_valid_next = 1'b1;
                        res_next       = '0;
                        res_next.last  = 1'b1;
                        unique case (req_type)
                            REQ_ADD:
                            begin
                                res_next.found = in_range;
                            end
                            REQ_REMOVE:
                            begin
                                res_next.found = in_range && sel_valid;
                            end
                            REQ_QUERY:
                            begin
                                res_next.found     = in_range && sel_valid;
                                res_next.remaining = (in_range && sel_valid) ? sel_rem : 16'd0;
                            end
                            default:
                            begin
                                res_next.found = 1'b0;
                            end
                        endcase
                    end
                end
            end
            ST_WALK:
            begin
                if (adv)
                begin
                    if (rec_sel.fire)
                    begin
                        if (pend_valid_reg)
                        begin
                            res_valid_next = 1'b1;
                            res_next       = fire_result(pend_reg, 1'b0);
                        end
                        pend_next       = rec_sel;
                        pend_valid_next = 1'b1;
                    end
                    if (tok_vec[SLOTS-1])
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        res_next = fire_result(pend_reg, 1'b1);
                    end
                    else
                    begin
                        res_next      = '0;
                        res_next.last = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            thresh_reg     <= THRESH_RESET;
            res_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            res_valid_reg  <= res_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_write_en)
            begin
                thresh_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        pend_reg <= pend_next;
        if (start)
        begin
            tick_reg <= tick_ms;
        end
    end

    assign res_valid   = res_valid_reg;
    assign fired       = res_reg.fired;
    assign fired_slot  = res_reg.fired_slot;
    assign fired_event = res_reg.fired_event;
    assign fired_arg   = res_reg.fired_arg;
    assign fire_count  = res_reg.fire_count;
    assign found       = res_reg.found;
    assign remaining   = res_reg.remaining;
    assign last        = res_reg.last;

    // The token is held by at most one cell, and by exactly one during a walk.
    a_tok_single : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("tick token held by more than one cell");

    a_tok_walk : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> $onehot(tok_vec))
        else $error("walk in progress without a token");

    a_tok_idle : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_WALK) |-> (tok_vec == '0))
        else $error("token present outside a walk");

    a_pend_idle : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("held firing record left over after a tick");

    a_single_res : assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && (req_type != REQ_TICK)) |=> (res_valid && last))
        else $error("single result request gave no final result");

endmodule
`default_nettype wire
